[sv/uqsp_pkg.sv]
// shared types and constants of the query string parser
package uqsp_pkg;

  localparam int unsigned LenW   = 16;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [7:0] ChPercent  = 8'h25;
  localparam logic [7:0] ChPlus     = 8'h2b;
  localparam logic [7:0] ChEquals   = 8'h3d;
  localparam logic [7:0] ChAmp      = 8'h26;
  localparam logic [7:0] ChQuestion = 8'h3f;
  localparam logic [7:0] ChSpace    = 8'h20;

  localparam logic CfgBufferBytes = 1'b0;
  localparam logic CfgMaxParams   = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_SEG_END   = 2'd1,
    KIND_PARSE_END = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_ESC  = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_TOO_MANY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_e;

  // results caused by one item, in delivery order byte, segment end, parse end
  typedef struct packed {
    logic            has_byte;
    logic            has_seg;
    logic            has_end;
    logic [7:0]      dec_byte;
    logic            in_value;
    logic [LenW-1:0] seg_len;
    status_e         status;
  } bundle_t;

endpackage

[sv/uqsp_front.sv]
// front end: per-byte parse state and result bundle generation
module uqsp_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [15:0]              cfg_data_i,
  input  logic                     take_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     has_byte_i,
  input  logic                     last_byte_i,
  output logic                     push_o,
  output uqsp_pkg::bundle_t        bundle_o
);

  localparam logic [uqsp_pkg::LenW-1:0] CntMax = '1;

  logic [15:0]               buffer_bytes_q, buffer_bytes_d;
  logic [7:0]                max_params_q, max_params_d;
  logic                      at_start_q, at_start_d;
  logic                      value_phase_q, value_phase_d;
  logic                      seg_enc_q, seg_enc_d;
  uqsp_pkg::esc_e            esc_q, esc_d;
  logic [3:0]                high_nib_q, high_nib_d;
  logic [uqsp_pkg::LenW-1:0] seg_cnt_q, seg_cnt_d;
  logic [15:0]               space_left_q, space_left_d;
  logic [7:0]                param_cnt_q, param_cnt_d;
  logic                      stopped_q, stopped_d;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    return v;
  endfunction

  function automatic logic [15:0] usable(input logic [15:0] bb);
    return (bb == 16'd0) ? 16'd0 : bb - 16'd1;
  endfunction

  always_comb begin
    logic [4:0]                hv;
    logic                      emit_b;
    logic [7:0]                b_val;
    logic                      do_close;
    logic                      delim;
    logic                      new_vp;
    logic [uqsp_pkg::LenW-1:0] cnt_mid;
    uqsp_pkg::status_e         err;
    logic                      seg_ok;

    buffer_bytes_d = buffer_bytes_q;
    max_params_d   = max_params_q;
    at_start_d     = at_start_q;
    value_phase_d  = value_phase_q;
    seg_enc_d      = seg_enc_q;
    esc_d          = esc_q;
    high_nib_d     = high_nib_q;
    seg_cnt_d      = seg_cnt_q;
    space_left_d   = space_left_q;
    param_cnt_d    = param_cnt_q;
    stopped_d      = stopped_q;

    hv       = hex_val(data_byte_i);
    emit_b   = 1'b0;
    b_val    = data_byte_i;
    do_close = 1'b0;
    delim    = 1'b0;
    new_vp   = value_phase_q;
    err      = uqsp_pkg::STAT_OK;
    seg_ok   = 1'b0;

    if (cfg_we_i) begin
      if (cfg_idx_i == uqsp_pkg::CfgBufferBytes) begin
        buffer_bytes_d = cfg_data_i;
        if (at_start_q) space_left_d = usable(cfg_data_i);
      end else begin
        max_params_d = cfg_data_i[7:0];
      end
    end

    if (take_i && !stopped_q && has_byte_i) begin
      at_start_d = 1'b0;
      if (at_start_q && data_byte_i == uqsp_pkg::ChQuestion) begin
        // leading question mark dropped
      end else if (esc_q == uqsp_pkg::ESC_HIGH) begin
        if (hv[4]) err = uqsp_pkg::STAT_BAD_ESC;
        else begin
          high_nib_d = hv[3:0];
          esc_d      = uqsp_pkg::ESC_LOW;
        end
      end else if (esc_q == uqsp_pkg::ESC_LOW) begin
        if (hv[4]) err = uqsp_pkg::STAT_BAD_ESC;
        else begin
          emit_b = 1'b1;
          b_val  = {high_nib_q, hv[3:0]};
          esc_d  = uqsp_pkg::ESC_IDLE;
        end
      end else if (data_byte_i == uqsp_pkg::ChPercent) begin
        seg_enc_d = 1'b1;
        esc_d     = uqsp_pkg::ESC_HIGH;
      end else if (data_byte_i == uqsp_pkg::ChPlus) begin
        seg_enc_d = 1'b1;
        emit_b    = 1'b1;
        b_val     = uqsp_pkg::ChSpace;
      end else if (data_byte_i == uqsp_pkg::ChAmp) begin
        do_close = 1'b1;
        delim    = 1'b1;
        new_vp   = 1'b0;
      end else if (data_byte_i == uqsp_pkg::ChEquals && !value_phase_q) begin
        do_close = 1'b1;
        delim    = 1'b1;
        new_vp   = 1'b1;
      end else begin
        emit_b = 1'b1;
      end
    end

    cnt_mid = (emit_b && seg_cnt_q != CntMax) ? seg_cnt_q + 1'b1 : seg_cnt_q;
    seg_cnt_d = cnt_mid;

    if (take_i && !stopped_q && err == uqsp_pkg::STAT_OK && last_byte_i) begin
      if (esc_d != uqsp_pkg::ESC_IDLE) err = uqsp_pkg::STAT_BAD_ESC;
      else if (cnt_mid != '0) do_close = 1'b1;
    end

    if (do_close && err == uqsp_pkg::STAT_OK) begin
      if (!value_phase_q && param_cnt_q >= max_params_q) begin
        err = uqsp_pkg::STAT_TOO_MANY;
      end else if (seg_enc_d && 16'(cnt_mid) >= space_left_q) begin
        err = uqsp_pkg::STAT_OVERFLOW;
      end else begin
        seg_ok = 1'b1;
        if (!value_phase_q) param_cnt_d = param_cnt_q + 8'd1;
        if (seg_enc_d) space_left_d = space_left_q - 16'(cnt_mid) - 16'd1;
        seg_cnt_d = '0;
        seg_enc_d = 1'b0;
        if (delim) value_phase_d = new_vp;
      end
    end

    if (take_i && !stopped_q && err != uqsp_pkg::STAT_OK) stopped_d = 1'b1;

    if (take_i && last_byte_i) begin
      at_start_d    = 1'b1;
      value_phase_d = 1'b0;
      seg_enc_d     = 1'b0;
      esc_d         = uqsp_pkg::ESC_IDLE;
      high_nib_d    = 4'd0;
      seg_cnt_d     = '0;
      space_left_d  = usable(buffer_bytes_q);
      param_cnt_d   = 8'd0;
      stopped_d     = 1'b0;
    end

    bundle_o.has_byte = emit_b;
    bundle_o.has_seg  = seg_ok;
    bundle_o.has_end  = (err != uqsp_pkg::STAT_OK) || last_byte_i;
    bundle_o.dec_byte = b_val;
    bundle_o.in_value = value_phase_q;
    bundle_o.seg_len  = cnt_mid;
    bundle_o.status   = err;
    push_o = take_i && !stopped_q
             && (emit_b || seg_ok || err != uqsp_pkg::STAT_OK || last_byte_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_bytes_q <= 16'd8192;
      max_params_q   <= 8'd64;
      at_start_q     <= 1'b1;
      value_phase_q  <= 1'b0;
      seg_enc_q      <= 1'b0;
      esc_q          <= uqsp_pkg::ESC_IDLE;
      high_nib_q     <= 4'd0;
      seg_cnt_q      <= '0;
      space_left_q   <= 16'd8191;
      param_cnt_q    <= 8'd0;
      stopped_q      <= 1'b0;
    end else begin
      buffer_bytes_q <= buffer_bytes_d;
      max_params_q   <= max_params_d;
      at_start_q     <= at_start_d;
      value_phase_q  <= value_phase_d;
      seg_enc_q      <= seg_enc_d;
      esc_q          <= esc_d;
      high_nib_q     <= high_nib_d;
      seg_cnt_q      <= seg_cnt_d;
      space_left_q   <= space_left_d;
      param_cnt_q    <= param_cnt_d;
      stopped_q      <= stopped_d;
    end
  end

endmodule

[sv/uqsp_queue.sv]
// small queue of result bundles between front and back end
module uqsp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  uqsp_pkg::bundle_t push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output uqsp_pkg::bundle_t head_o
);

  uqsp_pkg::bundle_t mem_q [uqsp_pkg::QDepth];

  logic [uqsp_pkg::QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [uqsp_pkg::QPtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (uqsp_pkg::QPtrW+1)'(uqsp_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = wr_q + 1'b1;
    if (pop_i) rd_d = rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[sv/uqsp_back.sv]
// back end: delivers the results of each bundle one at a time
module uqsp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  uqsp_pkg::bundle_t         head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                out_byte_o,
  output logic                      in_value_o,
  output logic [uqsp_pkg::LenW-1:0] segment_length_o,
  output logic [1:0]                status_o,
  output logic                      last_o
);

  logic [2:0] done_q, done_d;
  logic [2:0] pend;
  logic [2:0] cur;
  logic       take;

  assign pend = {head_i.has_end, head_i.has_seg, head_i.has_byte} & ~done_q;

  always_comb begin
    cur = 3'b000;
    if (pend[0]) cur = 3'b001;
    else if (pend[1]) cur = 3'b010;
    else if (pend[2]) cur = 3'b100;
  end

  assign out_valid_o = !empty_i;
  assign take        = out_valid_o && !out_stall_i;
  assign last_o      = (pend & ~cur) == 3'b000;
  assign pop_o       = take && last_o;

  always_comb begin
    kind_o           = uqsp_pkg::KIND_PARSE_END;
    out_byte_o       = 8'd0;
    in_value_o       = 1'b0;
    segment_length_o = '0;
    status_o         = head_i.status;
    if (cur[0]) begin
      kind_o     = uqsp_pkg::KIND_BYTE;
      out_byte_o = head_i.dec_byte;
      in_value_o = head_i.in_value;
      status_o   = uqsp_pkg::STAT_OK;
    end else if (cur[1]) begin
      kind_o           = uqsp_pkg::KIND_SEG_END;
      in_value_o       = head_i.in_value;
      segment_length_o = head_i.seg_len;
      status_o         = uqsp_pkg::STAT_OK;
    end
  end

  always_comb begin
    done_d = done_q;
    if (take) done_d = last_o ? 3'b000 : (done_q | cur);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 3'b000;
    else done_q <= done_d;
  end

endmodule

[sv/url_query_string_parser_unit.sv]
// top level of the query string parser
// Input channel: one item per handshake (in_valid_i high, in_stall_o low) carries
// a raw byte of the query string, a flag that the byte is present and a flag
// marking the final item of the string. Output channel: out_valid_o / out_stall_i
// carry result items: decoded bytes, segment-end records with the decoded length,
// and a parse-end record with its status; last_o marks the final result of an item.
// Each item is parsed in the cycle it is accepted and its results (zero to three)
// enter a four-entry queue as one bundle, offered once it reaches the queue head.
// Input rate is one item per cycle; the output delivers one result per cycle, so
// items that cause several results hold the input back once the queue fills.
// A stalled receiver freezes the current result; the input keeps being taken
// until the queue is full, then in_stall_o rises.
// Writes on cfg_we_i/cfg_idx_i/cfg_data_i are registered; a mid-string buffer size applies from the next string.
// Reset empties the queue, restores the register defaults and starts a new string.
module url_query_string_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic        in_value_o,
  output logic [15:0] segment_length_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  logic              full, empty, push, pop, take;
  uqsp_pkg::bundle_t push_data, head;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  uqsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .bundle_o    (push_data)
  );

  uqsp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  uqsp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .out_byte_o       (out_byte_o),
    .in_value_o       (in_value_o),
    .segment_length_o (segment_length_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the query string parser: random and directed strings
`timescale 1ns / 1ps

module tb_top;

  localparam int StallLimit = 5000;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
  } raw_item_t;

  typedef struct packed {
    uqsp_pkg::kind_e   kind;
    logic [7:0]        dec_byte;
    logic              in_val;
    logic [15:0]       seg_len;
    uqsp_pkg::status_e stat;
    logic              is_last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        has_byte_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic        in_value_o;
  logic [15:0] segment_length_o;
  logic [1:0]  status_o;
  logic        last_o;

  url_query_string_parser_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .out_byte_o       (out_byte_o),
    .in_value_o       (in_value_o),
    .segment_length_o (segment_length_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  raw_item_t   pending_items[$];
  result_t     due_results[$];
  logic [7:0]  draft[$];

  // predictor copy of registers and parse state
  logic [15:0]    buf_bytes_q;
  logic [7:0]     max_params_q;
  logic           at_start_q;
  logic           value_q;
  logic           encoded_q;
  uqsp_pkg::esc_e esc_q;
  logic [3:0]     nib_q;
  logic [15:0]    seg_len_q;
  logic [15:0]    space_q;
  logic [7:0]     params_q;
  logic           stopped_q;
  result_t        step_buf[4];
  int             step_n;

  logic calm = 1'b0;
  int   errors = 0;
  int   items_sent = 0;
  int   items_taken = 0;
  int   results_seen = 0;
  int   settings = 1;
  int   end_tally[4] = '{0, 0, 0, 0};
  int   hold_left = 0;
  int   hold_mark = 150;
  int   quiet_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] usable_space();
    return (buf_bytes_q == 16'd0) ? 16'd0 : buf_bytes_q - 16'd1;
  endfunction

  function automatic void restart_string();
    at_start_q = 1'b1;
    value_q    = 1'b0;
    encoded_q  = 1'b0;
    esc_q      = uqsp_pkg::ESC_IDLE;
    nib_q      = '0;
    seg_len_q  = '0;
    space_q    = usable_space();
    params_q   = '0;
    stopped_q  = 1'b0;
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    return 5'd16;
  endfunction

  function automatic void add_result(uqsp_pkg::kind_e k, logic [7:0] b, logic v,
                                     logic [15:0] len, uqsp_pkg::status_e s);
    step_buf[step_n] = '{kind: k, dec_byte: b, in_val: v, seg_len: len, stat: s,
                         is_last: 1'b0};
    step_n++;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    add_result(uqsp_pkg::KIND_BYTE, b, value_q, 16'd0, uqsp_pkg::STAT_OK);
    if (seg_len_q != 16'hFFFF) seg_len_q++;
  endfunction

  function automatic uqsp_pkg::status_e close_segment();
    if (!value_q) begin
      if (params_q >= max_params_q) return uqsp_pkg::STAT_TOO_MANY;
      params_q++;
    end
    if (encoded_q) begin
      if (seg_len_q >= space_q) return uqsp_pkg::STAT_OVERFLOW;
      space_q = space_q - (seg_len_q + 16'd1);
    end
    add_result(uqsp_pkg::KIND_SEG_END, 8'd0, value_q, seg_len_q, uqsp_pkg::STAT_OK);
    seg_len_q = '0;
    encoded_q = 1'b0;
    return uqsp_pkg::STAT_OK;
  endfunction

  function automatic void decode_item(logic [7:0] d, logic has, logic fin);
    uqsp_pkg::status_e err;
    logic              skip;
    logic [4:0]        hv;
    err = uqsp_pkg::STAT_OK;
    skip = 1'b0;
    step_n = 0;
    hv = hex_digit(d);
    if (stopped_q) begin
      if (fin) restart_string();
      return;
    end
    if (has) begin
      if (at_start_q) begin
        at_start_q = 1'b0;
        skip = (d == uqsp_pkg::ChQuestion);
      end
      if (!skip) begin
        if (esc_q == uqsp_pkg::ESC_HIGH) begin
          if (hv > 5'd15) err = uqsp_pkg::STAT_BAD_ESC;
          else begin
            nib_q = hv[3:0];
            esc_q = uqsp_pkg::ESC_LOW;
          end
        end else if (esc_q == uqsp_pkg::ESC_LOW) begin
          if (hv > 5'd15) err = uqsp_pkg::STAT_BAD_ESC;
          else begin
            add_byte({nib_q, hv[3:0]});
            esc_q = uqsp_pkg::ESC_IDLE;
          end
        end else if (d == uqsp_pkg::ChPercent) begin
          encoded_q = 1'b1;
          esc_q = uqsp_pkg::ESC_HIGH;
        end else if (d == uqsp_pkg::ChPlus) begin
          encoded_q = 1'b1;
          add_byte(uqsp_pkg::ChSpace);
        end else if (d == uqsp_pkg::ChAmp) begin
          err = close_segment();
          if (err == uqsp_pkg::STAT_OK) value_q = 1'b0;
        end else if (d == uqsp_pkg::ChEquals && !value_q) begin
          err = close_segment();
          if (err == uqsp_pkg::STAT_OK) value_q = 1'b1;
        end else begin
          add_byte(d);
        end
      end
    end
    if (err == uqsp_pkg::STAT_OK && fin) begin
      if (esc_q != uqsp_pkg::ESC_IDLE) err = uqsp_pkg::STAT_BAD_ESC;
      else if (seg_len_q > 16'd0) err = close_segment();
      if (err == uqsp_pkg::STAT_OK) begin
        add_result(uqsp_pkg::KIND_PARSE_END, 8'd0, 1'b0, 16'd0, uqsp_pkg::STAT_OK);
      end
    end
    if (err != uqsp_pkg::STAT_OK) begin
      add_result(uqsp_pkg::KIND_PARSE_END, 8'd0, 1'b0, 16'd0, err);
      stopped_q = 1'b1;
    end
    if (fin) restart_string();
    if (step_n > 0) step_buf[step_n-1].is_last = 1'b1;
    for (int i = 0; i < step_n; i++) due_results = {due_results, step_buf[i]};
  endfunction

  function automatic void push_item(logic [7:0] d, logic has, logic fin);
    raw_item_t it;
    it = '{data: d, has: has, fin: fin};
    pending_items = {pending_items, it};
    if (has || fin) items_sent++;
  endfunction

  function automatic void push_text(string s, logic with_marker);
    for (int i = 0; i < s.len(); i++) begin
      push_item(s[i], 1'b1, !with_marker && i == s.len() - 1);
    end
    if (with_marker) push_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v, logic lower);
    if (v < 4'd10) return 8'("0" + v);
    return 8'((lower ? "a" : "A") + v - 10);
  endfunction

  function automatic void add_char(logic [7:0] c);
    draft = {draft, c};
  endfunction

  function automatic void add_segment();
    string      plain;
    int         n;
    int         pick;
    logic [7:0] v;
    logic       lower;
    plain = "abcxyzABCXYZ0189-_.~";
    n = $urandom_range(6);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        add_char(plain[$urandom_range(plain.len() - 1)]);
      end else if (pick < 75) begin
        add_char(uqsp_pkg::ChPlus);
      end else if (pick < 95) begin
        v = 8'($urandom_range(255));
        lower = 1'($urandom_range(1));
        add_char(uqsp_pkg::ChPercent);
        add_char(hex_char(v[7:4], lower));
        add_char(hex_char(v[3:0], lower));
      end else begin
        add_char(uqsp_pkg::ChEquals);
      end
    end
  endfunction

  // mostly well-formed strings, some cut short, some random noise
  function automatic void gen_string(logic finish);
    string specials;
    int    r;
    int    np;
    int    n;
    logic  marker;
    specials = "%+=&?4aFg ";
    draft.delete();
    r = $urandom_range(99);
    if (r < 15) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(1) == 0) add_char(8'($urandom_range(255)));
        else add_char(specials[$urandom_range(specials.len() - 1)]);
      end
    end else begin
      if ($urandom_range(3) == 0) add_char(uqsp_pkg::ChQuestion);
      np = $urandom_range(1, 5);
      for (int p = 0; p < np; p++) begin
        add_segment();
        if ($urandom_range(3) != 0) begin
          add_char(uqsp_pkg::ChEquals);
          add_segment();
        end
        if (p < np - 1) add_char(uqsp_pkg::ChAmp);
      end
      if ($urandom_range(7) == 0) add_char(uqsp_pkg::ChAmp);
      if (r < 30 && draft.size() > 0) begin
        n = $urandom_range(draft.size() - 1);
        while (draft.size() > n) void'(draft.pop_back());
      end
    end
    marker = (draft.size() == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < draft.size(); i++) begin
      if ($urandom_range(15) == 0) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
      push_item(draft[i], 1'b1, finish && !marker && i == draft.size() - 1);
    end
    if (finish && marker) push_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endfunction

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == uqsp_pkg::CfgBufferBytes) begin
      buf_bytes_q = val;
      if (at_start_q) space_q = usable_space();
    end else begin
      max_params_q = val[7:0];
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || due_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i) begin : feed_items
    raw_item_t it;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_item(data_byte_i, has_byte_i, last_byte_i);
        items_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 37)) begin
          it = pending_items.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= it.data;
          has_byte_i  <= it.has;
          last_byte_i <= it.fin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (kind_o == uqsp_pkg::KIND_PARSE_END) end_tally[status_o]++;
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d byte %0d", kind_o, out_byte_o);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (kind_o != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_o);
            errors++;
          end
          if (out_byte_o != want.dec_byte) begin
            $error("out_byte: expected %0d, got %0d", want.dec_byte, out_byte_o);
            errors++;
          end
          if (in_value_o != want.in_val) begin
            $error("in_value: expected %0d, got %0d", want.in_val, in_value_o);
            errors++;
          end
          if (segment_length_o != want.seg_len) begin
            $error("segment_length: expected %0d, got %0d", want.seg_len, segment_length_o);
            errors++;
          end
          if (status_o != want.stat) begin
            $error("status: expected %0d, got %0d", want.stat, status_o);
            errors++;
          end
          if (last_o != want.is_last) begin
            $error("last: expected %0d, got %0d", want.is_last, last_o);
            errors++;
          end
        end
      end
      // long hold-off lets the result queue fill and back up the input
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (results_seen >= hold_mark) begin
        hold_left = 120;
        hold_mark += 350;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 37);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no handshake for %0d cycles", StallLimit);
        $display("FAIL url_query_string_parser_unit");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] buf_set[5];
    logic [7:0]  max_set[5];
    int          start;
    buf_set = '{16'd65535, 16'd40, 16'd1000, 16'd1, 16'd8192};
    max_set = '{8'd255, 8'd3, 8'd8, 8'd255, 8'd64};
    buf_bytes_q = 16'd8192;
    max_params_q = 8'd64;
    restart_string();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: escapes in both cases, plus, raw extremes, bad and cut escapes
    push_text("?n=%4a%fF+&", 1'b1);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(uqsp_pkg::ChEquals, 1'b1, 1'b0);
    push_item(uqsp_pkg::ChEquals, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);
    push_text("%gx", 1'b1);
    push_text("%4", 1'b0);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'hA5, 1'b0, 1'b1);
    drain();

    // smallest settings: too many params and overflow
    write_reg(uqsp_pkg::CfgBufferBytes, 16'd1);
    write_reg(uqsp_pkg::CfgMaxParams, 16'd1);
    settings++;
    push_text("a&b", 1'b0);
    push_text("+", 1'b0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(uqsp_pkg::CfgBufferBytes, buf_set[ph]);
      write_reg(uqsp_pkg::CfgMaxParams, {8'd0, max_set[ph]});
      settings++;
      calm = (ph == 2);
      start = items_sent;
      while (items_sent - start < 100) gen_string(1'b1);
      // leave a string open across the next register change
      if (ph == 1) gen_string(1'b0);
      drain();
    end
    calm = 1'b0;

    $display("%0d items taken under %0d register settings, %0d results checked",
             items_taken, settings, results_seen);
    $display("parse ends: %0d ok, %0d bad escape, %0d overflow, %0d too many params",
             end_tally[0], end_tally[1], end_tally[2], end_tally[3]);
    if (errors == 0) begin
      $display("PASS url_query_string_parser_unit");
    end else begin
      $display("FAIL url_query_string_parser_unit");
    end
    $finish;
  end

endmodule
